// ===== rtl/sff_pkg.sv =====
// Shared types and constants for the segmented flash FIFO.
package sff_pkg;

	localparam int ORG_W = 12;
	localparam int LEN_W = 13;
	localparam int CNT_W = 16;
	localparam int ESEG_W = 3;
	localparam int EPOCH_W = 2;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_SPACE = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_BAD_CFG  = 2'd3;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic cfg_idx_t;
	localparam cfg_idx_t CFG_ORIGIN = 1'b0;
	localparam cfg_idx_t CFG_LENGTH = 1'b1;

	// one store entry: byte plus the erase epoch of its segment at write time
	typedef struct packed {
		logic [EPOCH_W-1:0] stamp;
		logic [7:0]         data;
	} cell_t;

	typedef struct packed {
		status_t             status;
		logic                pop_ok;
		logic [EPOCH_W-1:0]  epoch;
		logic                erase_done;
		logic [ESEG_W-1:0]   erase_segment;
		logic [CNT_W-1:0]    call_bytes;
	} res_t;

endpackage

// ===== rtl/sff_if.sv =====
// Handshake channel interfaces: input items, results and configuration writes.
interface sff_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_in;
	logic       last_byte;

	modport source (output valid, op, data_in, last_byte, input ready);
	modport sink   (input valid, op, data_in, last_byte, output ready);
endinterface

interface sff_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  data_out;
	logic        erase_done;
	logic [2:0]  erase_segment;
	logic [15:0] call_bytes;

	modport source (output valid, status, data_out, erase_done, erase_segment, call_bytes,
		input ready);
	modport sink   (input valid, status, data_out, erase_done, erase_segment, call_bytes,
		output ready);
endinterface

interface sff_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [12:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/segmented_flash_fifo_top.sv =====
// Segmented flash FIFO: a byte FIFO in a segmented store with segment erase reporting.
//
// Channels: item (op, data_in, last_byte) in, result (status, data_out, erase_done,
// erase_segment, call_bytes) out, and cfg for register writes (index 0 region_origin,
// index 1 region_length). Every transaction on item yields exactly one result.
// cfg is always ready; write it only while no item is in flight.
//
// An item accepted at one edge shows its registered result after that edge. Throughput
// is one item per cycle unless stalled; the result register and a store with a
// registered read port set that figure. item.ready drops only while a result is held
// and the receiver stalls; the held result and its popped byte stay stable meanwhile.
//
// Reset clears the region to origin 0, length 4096, both pointers to the origin, the
// call count and the segment erase epochs. The byte store itself is not cleared: erase
// is tracked by a per-segment epoch stamped into each entry, so a popped byte whose
// segment was erased after it was written reads as 0xFF.
module segmented_flash_fifo_top #(
	parameter int STORE_BYTES   = 4096,
	parameter int SEGMENT_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	sff_item_if.sink            item,
	sff_result_if.source        result,
	sff_cfg_if.sink             cfg
);
	import sff_pkg::*;

	localparam int PW = $clog2(STORE_BYTES);

	logic          step;
	logic          valid_q;
	res_t          res;
	res_t          res_q;
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          mem_re;
	logic [PW-1:0] mem_raddr;
	cell_t         mem_rdata;

	assign cfg.ready  = 1'b1;
	assign item.ready = !valid_q || result.ready;
	assign step       = item.valid && item.ready;

	sff_ctrl #(
		.STORE_BYTES   (STORE_BYTES),
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.step      (step),
		.op        (item.op),
		.data_in   (item.data_in),
		.last_byte (item.last_byte),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	sff_store #(
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign result.valid         = valid_q;
	assign result.status        = res_q.status;
	assign result.erase_done    = res_q.erase_done;
	assign result.erase_segment = res_q.erase_segment;
	assign result.call_bytes    = res_q.call_bytes;
	// stale epoch means the segment was erased since the byte went in
	assign result.data_out      = !res_q.pop_ok ? 8'h00 :
		((mem_rdata.stamp == res_q.epoch) ? mem_rdata.data : 8'hFF);

endmodule

// ===== rtl/sff_store.sv =====
// Byte store with per-entry erase stamp, one write and one registered read port.
module sff_store #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  sff_pkg::cell_t             wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output sff_pkg::cell_t             rdata
);
	import sff_pkg::*;

	cell_t mem [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sff_ctrl.sv =====
// Region registers, pointers, free count, call counter and segment erase epochs.
module sff_ctrl #(
	parameter int STORE_BYTES   = 4096,
	parameter int SEGMENT_BYTES = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  sff_pkg::cfg_idx_t                cfg_index,
	input  logic [sff_pkg::LEN_W-1:0]        cfg_data,
	input  logic                             step,
	input  logic                             op,
	input  logic [7:0]                       data_in,
	input  logic                             last_byte,
	output sff_pkg::res_t                    res,
	output logic                             mem_we,
	output logic [$clog2(STORE_BYTES)-1:0]   mem_waddr,
	output sff_pkg::cell_t                   mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(STORE_BYTES)-1:0]   mem_raddr
);
	import sff_pkg::*;

	localparam int PW        = $clog2(STORE_BYTES);
	localparam int SEG_SHIFT = $clog2(SEGMENT_BYTES);
	localparam int NSEG      = (STORE_BYTES + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
	localparam int SGW       = (NSEG > 1) ? $clog2(NSEG) : 1;
	localparam int CW        = (PW + 1 > ORG_W + 2) ? PW + 1 : ORG_W + 2;

	logic [ORG_W-1:0]   origin_q;
	logic [LEN_W-1:0]   length_q;
	logic [PW-1:0]      wp_q;
	logic [PW-1:0]      rp_q;
	logic [LEN_W-1:0]   free_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EPOCH_W-1:0] epoch_q [NSEG];

	logic [CW-1:0]      org_x;
	logic [PW-1:0]      org_p;
	logic [CW-1:0]      cfg_org_x;
	logic [CW-1:0]      region_end;
	logic               bad;
	logic [CW-1:0]      wp_x;
	logic [CW-1:0]      wp_inc;
	logic [PW-1:0]      wp_nx;
	logic [CW-1:0]      rp_x;
	logic [CW-1:0]      rp_inc;
	logic [PW-1:0]      rp_nx;
	logic [CW-1:0]      wseg;
	logic [CW-1:0]      rseg;
	logic [CW-1:0]      rseg_nx;
	logic [SGW-1:0]     wseg_i;
	logic [SGW-1:0]     rseg_i;
	logic               push_ok;
	logic               pop_ok;
	logic               push_erase;
	logic               pop_erase;
	logic [CNT_W-1:0]   cnt_inc;
	logic [EPOCH_W-1:0] wepoch;
	status_t            status;

	assign org_x      = CW'(origin_q);
	assign org_p      = org_x[PW-1:0];
	assign cfg_org_x  = CW'(cfg_data[ORG_W-1:0]);
	assign region_end = org_x + CW'(length_q);
	assign bad        = region_end > CW'(STORE_BYTES);

	assign wp_x   = CW'(wp_q);
	assign wp_inc = wp_x + CW'(1);
	assign wp_nx  = (wp_inc >= region_end) ? org_p : wp_inc[PW-1:0];
	assign rp_x   = CW'(rp_q);
	assign rp_inc = rp_x + CW'(1);
	assign rp_nx  = (rp_inc >= region_end) ? org_p : rp_inc[PW-1:0];

	assign wseg    = wp_x >> SEG_SHIFT;
	assign rseg    = rp_x >> SEG_SHIFT;
	assign rseg_nx = CW'(rp_nx) >> SEG_SHIFT;
	assign wseg_i  = wseg[SGW-1:0];
	assign rseg_i  = rseg[SGW-1:0];

	assign push_ok    = step && !bad && (op == OP_PUSH) && (free_q != '0);
	assign pop_ok     = step && !bad && (op == OP_POP) && (free_q < length_q);
	assign push_erase = push_ok && (wp_x[SEG_SHIFT-1:0] == '0);
	// the read pointer crossed a segment boundary (or wrapped into another one)
	assign pop_erase  = pop_ok && (rseg_nx != rseg);

	assign cnt_inc = ((push_ok || pop_ok) && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		if (bad) begin
			status = ST_BAD_CFG;
		end else if (op == OP_PUSH) begin
			status = (free_q == '0) ? ST_NO_SPACE : ST_OK;
		end else begin
			status = (free_q >= length_q) ? ST_EMPTY : ST_OK;
		end
	end

	always_comb begin
		res.status        = status;
		res.pop_ok        = pop_ok;
		res.epoch         = epoch_q[rseg_i];
		res.erase_done    = push_erase || pop_erase;
		res.erase_segment = push_erase ? wseg[ESEG_W-1:0] :
			(pop_erase ? rseg[ESEG_W-1:0] : '0);
		res.call_bytes    = cnt_inc;
	end

	// a byte written right after its segment's erase carries the new epoch
	assign wepoch = push_erase ? epoch_q[wseg_i] + EPOCH_W'(1) : epoch_q[wseg_i];

	assign mem_we          = push_ok;
	assign mem_waddr       = wp_q;
	assign mem_wdata.stamp = wepoch;
	assign mem_wdata.data  = data_in;
	assign mem_re          = pop_ok;
	assign mem_raddr       = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			length_q <= LEN_RESET;
			wp_q     <= '0;
			rp_q     <= '0;
			free_q   <= LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN: begin
					origin_q <= cfg_data[ORG_W-1:0];
					wp_q     <= cfg_org_x[PW-1:0];
					rp_q     <= cfg_org_x[PW-1:0];
					free_q   <= length_q;
				end
				CFG_LENGTH: begin
					length_q <= cfg_data;
					wp_q     <= org_p;
					rp_q     <= org_p;
					free_q   <= cfg_data;
				end
				default: begin
					origin_q <= origin_q;
				end
			endcase
		end else begin
			if (push_ok) begin
				wp_q   <= wp_nx;
				free_q <= free_q - LEN_W'(1);
			end
			if (pop_ok) begin
				rp_q   <= rp_nx;
				free_q <= free_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= last_byte ? '0 : cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSEG; i++) begin
				epoch_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NSEG; i++) begin
				if ((push_erase && wseg_i == SGW'(i)) || (pop_erase && rseg_i == SGW'(i))) begin
					epoch_q[i] <= epoch_q[i] + EPOCH_W'(1);
				end
			end
		end
	end

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= length_q)
		else $error("free count above region length");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (wp_q == rp_q) && (free_q == length_q))
		else $error("pointers not restarted after register write");

	a_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && bad && !cfg_we) |=> $stable(wp_q) && $stable(rp_q) && $stable(free_q))
		else $error("state moved under bad region");

	a_wp_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(!bad && length_q != '0) |-> (wp_x >= org_x) && (wp_x < region_end))
		else $error("write pointer outside region");

endmodule

// ===== tb/segmented_flash_fifo_top_tb.sv =====
// Testbench for the segmented flash FIFO: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module segmented_flash_fifo_top_tb;
	import sff_pkg::*;

	localparam int STORE_BYTES   = 4096;
	localparam int SEGMENT_BYTES = 512;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int COUNT_MAX     = 65535;

	typedef struct packed {
		status_t     status;
		logic [7:0]  data_out;
		logic        erase_done;
		logic [2:0]  erase_segment;
		logic [15:0] call_bytes;
	} step_result_t;

	logic clk;
	logic arst_n;

	sff_item_if   item_ch ();
	sff_result_if res_ch ();
	sff_cfg_if    cfg_ch ();

	segmented_flash_fifo_top #(
		.STORE_BYTES  (STORE_BYTES),
		.SEGMENT_BYTES(SEGMENT_BYTES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	// predictor state
	logic [7:0] flash_img [STORE_BYTES];
	int fifo_origin;
	int fifo_length;
	int wr_ptr;
	int rd_ptr;
	int free_cnt;
	int call_cnt;

	step_result_t pending_results [$];
	step_result_t want;

	int send_gap_max;
	int recv_stall_max;
	int hold_req;
	int errors;
	int cycle_count;
	int n_checked;
	int n_ok;
	int n_full;
	int n_empty;
	int n_bad;
	int n_erase;
	int n_cfg_writes;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
			$display("segmented_flash_fifo_top test failed");
			$finish;
		end
	end

	function automatic int wrap_next(int p);
		int n;
		n = p + 1;
		if (n >= fifo_origin + fifo_length)
			n = fifo_origin;
		return n;
	endfunction

	function automatic void wipe_segment(int seg);
		int i;
		for (i = seg * SEGMENT_BYTES; i < (seg + 1) * SEGMENT_BYTES; i++)
			if (i < STORE_BYTES)
				flash_img[i] = 8'hFF;
	endfunction

	function automatic void restart_pointers();
		wr_ptr = fifo_origin;
		rd_ptr = fifo_origin;
		free_cnt = fifo_length;
	endfunction

	// expected result of one accepted transaction; advances the predicted state
	function automatic step_result_t fifo_step(logic op, logic [7:0] din, logic last);
		step_result_t r;
		bit moved;
		int old_seg;
		r = '0;
		moved = 0;
		if (fifo_origin + fifo_length > STORE_BYTES) begin
			r.status = ST_BAD_CFG;
		end else if (op == OP_PUSH) begin
			if (free_cnt == 0) begin
				r.status = ST_NO_SPACE;
			end else begin
				if (wr_ptr % SEGMENT_BYTES == 0) begin
					r.erase_done = 1'b1;
					r.erase_segment = 3'(wr_ptr / SEGMENT_BYTES);
					wipe_segment(wr_ptr / SEGMENT_BYTES);
				end
				flash_img[wr_ptr] = din;
				wr_ptr = wrap_next(wr_ptr);
				free_cnt--;
				moved = 1;
			end
		end else begin
			if (free_cnt >= fifo_length) begin
				r.status = ST_EMPTY;
			end else begin
				old_seg = rd_ptr / SEGMENT_BYTES;
				r.data_out = flash_img[rd_ptr];
				rd_ptr = wrap_next(rd_ptr);
				// leaving a segment erases it
				if (rd_ptr / SEGMENT_BYTES != old_seg) begin
					r.erase_done = 1'b1;
					r.erase_segment = 3'(old_seg);
					wipe_segment(old_seg);
				end
				free_cnt++;
				moved = 1;
			end
		end
		if (moved && call_cnt < COUNT_MAX)
			call_cnt++;
		r.call_bytes = 16'(call_cnt);
		if (last)
			call_cnt = 0;
		return r;
	endfunction

	task automatic send_item(logic op, logic [7:0] din, logic last);
		int gap;
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.op        <= op;
		item_ch.data_in   <= din;
		item_ch.last_byte <= last;
		do @(posedge clk); while (!item_ch.ready);
		pending_results.push_back(fifo_step(op, din, last));
	endtask

	// stop offering items and let every pending result come out
	task automatic settle_idle();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_region_reg(cfg_idx_t idx, logic [12:0] val);
		settle_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_ORIGIN)
			fifo_origin = int'(val[11:0]);
		else
			fifo_length = int'(val);
		restart_pointers();
		n_cfg_writes++;
	endtask

	task automatic set_region(int org, int len);
		write_region_reg(CFG_ORIGIN, 13'(org));
		write_region_reg(CFG_LENGTH, 13'(len));
	endtask

	// receiver: random stall per result, or a long hold-off on request
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end else begin
				stall = $urandom_range(recv_stall_max, 0);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	function automatic void report(string field, int exp_v, logic [15:0] act_v);
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
		errors++;
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction pending, status %0d", $time,
					res_ch.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				case (want.status)
					ST_OK:       n_ok++;
					ST_NO_SPACE: n_full++;
					ST_EMPTY:    n_empty++;
					default:     n_bad++;
				endcase
				if (want.erase_done)
					n_erase++;
				if (res_ch.status !== want.status)
					report("status", want.status, 16'(res_ch.status));
				if (res_ch.data_out !== want.data_out)
					report("data_out", want.data_out, 16'(res_ch.data_out));
				if (res_ch.erase_done !== want.erase_done)
					report("erase_done", want.erase_done, 16'(res_ch.erase_done));
				if (res_ch.erase_segment !== want.erase_segment)
					report("erase_segment", want.erase_segment, 16'(res_ch.erase_segment));
				if (res_ch.call_bytes !== want.call_bytes)
					report("call_bytes", want.call_bytes, res_ch.call_bytes);
			end
		end
	end

	task automatic test_reset_defaults();
		send_item(OP_POP, 8'h5A, 1'b1);
		send_item(OP_PUSH, 8'h00, 1'b0);
		send_item(OP_PUSH, 8'hFF, 1'b1);
		send_item(OP_POP, 8'h00, 1'b0);
		send_item(OP_POP, 8'hFF, 1'b1);
		send_item(OP_POP, 8'h00, 1'b0);
	endtask

	task automatic test_region_extremes();
		// origin with the unused top bit set, one-byte region at the store end
		write_region_reg(CFG_ORIGIN, 13'h1FFF);
		write_region_reg(CFG_LENGTH, 13'd1);
		send_item(OP_PUSH, 8'hA5, 1'b0);
		send_item(OP_PUSH, 8'h3C, 1'b0);
		send_item(OP_POP, 8'h00, 1'b0);
		send_item(OP_POP, 8'h00, 1'b1);
		write_region_reg(CFG_LENGTH, 13'd0);
		send_item(OP_PUSH, 8'h81, 1'b0);
		send_item(OP_POP, 8'h7E, 1'b1);
		write_region_reg(CFG_LENGTH, 13'd4096);
		send_item(OP_PUSH, 8'h11, 1'b0);
		send_item(OP_POP, 8'h22, 1'b1);
		set_region(0, 13'h1FFF);
		send_item(OP_PUSH, 8'h33, 1'b0);
		set_region(3584, 512);
		send_item(OP_PUSH, 8'hC3, 1'b0);
		send_item(OP_POP, 8'h00, 1'b1);
	endtask

	// region straddles a segment boundary and its origin is not segment aligned
	task automatic test_unaligned_wrap();
		int i;
		set_region(510, 4);
		for (i = 0; i < 5; i++)
			send_item(OP_PUSH, 8'(8'h40 + i), 1'b0);
		send_item(OP_POP, 8'h00, 1'b0);
		send_item(OP_POP, 8'h00, 1'b0);
		send_item(OP_PUSH, 8'h9D, 1'b0);
		send_item(OP_PUSH, 8'h9E, 1'b1);
		for (i = 0; i < 4; i++)
			send_item(OP_POP, 8'h00, i == 3);
	endtask

	task automatic test_stall_and_pause();
		int i;
		set_region(1000, 20);
		send_gap_max = 0;
		recv_stall_max = 0;
		hold_req = 300;
		for (i = 0; i < 40; i++)
			send_item(i[0] ? OP_POP : OP_PUSH, 8'($urandom_range(255)), i % 9 == 8);
		// sender waits for everything outstanding before going on
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		send_gap_max = 6;
		recv_stall_max = 6;
		for (i = 0; i < 30; i++)
			send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
				$urandom_range(3) == 0);
	endtask

	task automatic test_random_traffic();
		int phase, kind, org, len, quota, sent, mode, burst, k, cap;
		logic op;
		for (phase = 0; phase < 8; phase++) begin
			kind = $urandom_range(9);
			case (kind)
				0: begin
					org = $urandom_range(4095);
					len = $urandom_range(8191, 4097 - org);
				end
				1: begin
					org = $urandom_range(4095);
					len = 0;
				end
				2: begin
					org = $urandom_range(7) * SEGMENT_BYTES;
					len = $urandom_range(64, 1);
				end
				7, 8: begin
					org = $urandom_range(3000);
					len = $urandom_range(1100, 256);
				end
				9: begin
					len = $urandom_range(600, 1);
					org = STORE_BYTES - len;
				end
				default: begin
					org = $urandom_range(4095);
					len = $urandom_range(64, 1);
					if (org + len > STORE_BYTES)
						len = STORE_BYTES - org;
				end
			endcase
			write_region_reg(CFG_ORIGIN, {1'($urandom_range(1)), 12'(org)});
			write_region_reg(CFG_LENGTH, 13'(len));
			if ($urandom_range(3) == 0) begin
				send_gap_max = 0;
				recv_stall_max = 0;
			end else begin
				send_gap_max = 6;
				recv_stall_max = 6;
			end
			// degenerate regions (bad or zero length) never move data, so they get a shorter quota
			quota = (kind <= 1) ? 30 : 250;
			cap = (len > 0 && len < 60) ? len + 3 : 60;
			sent = 0;
			while (sent < quota) begin
				mode = $urandom_range(3);
				burst = $urandom_range(cap, 1);
				for (k = 0; k < ((mode == 1) ? 2 * burst : burst); k++) begin
					case (mode)
						0:       op = 1'($urandom_range(1));
						1:       op = (k < burst) ? OP_PUSH : OP_POP;
						2:       op = ($urandom_range(3) == 0) ? OP_POP : OP_PUSH;
						default: op = ($urandom_range(3) == 0) ? OP_PUSH : OP_POP;
					endcase
					send_item(op, 8'($urandom_range(255)), $urandom_range(7) == 0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < STORE_BYTES; i++)
			flash_img[i] = 8'h00;
		fifo_origin = 0;
		fifo_length = STORE_BYTES;
		call_cnt = 0;
		restart_pointers();
		send_gap_max = 6;
		recv_stall_max = 6;
		hold_req = 0;
		errors = 0;
		cycle_count = 0;
		n_checked = 0;
		n_ok = 0;
		n_full = 0;
		n_empty = 0;
		n_bad = 0;
		n_erase = 0;
		n_cfg_writes = 0;

		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.op        <= OP_PUSH;
		item_ch.data_in   <= 8'h00;
		item_ch.last_byte <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_ORIGIN;
		cfg_ch.data       <= 13'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_region_extremes();
		test_unaligned_wrap();
		test_stall_and_pause();
		test_random_traffic();

		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d transactions: %0d ok, %0d no-space, %0d empty, %0d bad region",
			n_checked, n_ok, n_full, n_empty, n_bad);
		$display("%0d segment erases seen, %0d register writes, long receiver hold and drain",
			n_erase, n_cfg_writes);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("segmented_flash_fifo_top test passed");
		end else begin
			$display("segmented_flash_fifo_top test failed");
		end
		$finish;
	end

endmodule
